@@ sv/llb_pkg.sv @@
// Shared widths, register indexes, reset values and config bundle for the light decay blur.
package llb_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned DecayW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned ProdW    = LevelW + DecayW;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegEpsilon    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDecayAir   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDecaySolid = 2'd2;

  // Reset values
  localparam logic [LevelW-1:0] EpsilonRst    = 8'd2;
  localparam logic [DecayW-1:0] DecayAirRst   = 9'd230;
  localparam logic [DecayW-1:0] DecaySolidRst = 9'd150;

  typedef struct packed {
    logic [LevelW-1:0] epsilon;
    logic [DecayW-1:0] decay_air;
    logic [DecayW-1:0] decay_solid;
  } cfg_t;

endpackage

@@ sv/llb_cfg.sv @@
// Configuration register file: epsilon and the two decay factors.
module llb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [llb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [llb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output llb_pkg::cfg_t                 cfg_o
);
  import llb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEpsilon:    cfg_d.epsilon     = cfg_wdata_i[LevelW-1:0];
        RegDecayAir:   cfg_d.decay_air   = cfg_wdata_i[DecayW-1:0];
        RegDecaySolid: cfg_d.decay_solid = cfg_wdata_i[DecayW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.epsilon     <= EpsilonRst;
      cfg_q.decay_air   <= DecayAirRst;
      cfg_q.decay_solid <= DecaySolidRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/llb_lane.sv @@
// One color channel: epsilon cut, max with incoming, decayed carry register.
module llb_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        first_i,
  input  logic [llb_pkg::LevelW-1:0]  level_i,
  input  logic [llb_pkg::DecayW-1:0]  decay_i,
  input  logic [llb_pkg::LevelW-1:0]  epsilon_i,
  output logic [llb_pkg::LevelW-1:0]  level_o
);
  import llb_pkg::*;

  logic [LevelW-1:0] carry_q, carry_d;
  logic [LevelW-1:0] carry;
  logic [LevelW-1:0] live;
  logic [ProdW-1:0]  prod;
  logic [DecayW-1:0] scaled;

  // Line start reloads the carry from the pixel itself
  assign carry = first_i ? level_i : carry_q;
  // Carry below epsilon counts as dark
  assign live  = (carry < epsilon_i) ? '0 : carry;
  assign level_o = (live < level_i) ? level_i : live;

  // Q1.8 decay, floor, saturate to the level range
  assign prod    = ProdW'(level_o) * ProdW'(decay_i);
  assign scaled  = prod[ProdW-1:LevelW];
  assign carry_d = scaled[DecayW-1] ? {LevelW{1'b1}} : scaled[LevelW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (adv_i) begin
      carry_q <= carry_d;
    end
  end

endmodule

@@ sv/line_light_decay_blur.sv @@
// Top level of the line light decay blur: input register, three lanes, result register.
//
// Usage:
//   Pixels of a line enter on the in channel (in_valid_i / in_stall_o) in order,
//   first_in_line_i marking the first pixel of each line. Each request gives one
//   result on the out channel (out_valid_o / out_stall_i) with the blurred RGB
//   levels and the fully_decayed flag.
//   A request accepted into the input register moves on to the result register,
//   and so to the outputs, whenever the result register is empty or being taken.
//   Throughput: one pixel per cycle while not stalled. The carried light of each
//   channel sits in a lane register updated in the same cycle the pixel moves
//   from the input to the result register (compare, max and an 8x9 multiply).
//   Stall: a held result keeps its payload; the input register still takes one
//   more request, and in_stall_o rises only while both registers are full and
//   the receiver stalls.
//   Reset: both registers empty, carried light zero, pending material air,
//   epsilon 2, air decay 230, solid decay 150.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the next
//   edge and are meant for an idle block.
module line_light_decay_blur (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [llb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [llb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input pixels
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [llb_pkg::LevelW-1:0]    red_in_i,
  input  logic [llb_pkg::LevelW-1:0]    green_in_i,
  input  logic [llb_pkg::LevelW-1:0]    blue_in_i,
  input  logic                          solid_i,
  input  logic                          first_in_line_i,
  input  logic                          edge_solid_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [llb_pkg::LevelW-1:0]    red_out_o,
  output logic [llb_pkg::LevelW-1:0]    green_out_o,
  output logic [llb_pkg::LevelW-1:0]    blue_out_o,
  output logic                          fully_decayed_o
);
  import llb_pkg::*;

  cfg_t cfg;

  logic              in_vld_q;
  logic [LevelW-1:0] in_red_q, in_green_q, in_blue_q;
  logic              in_solid_q, in_first_q, in_edge_q;
  logic              pend_solid_q;

  logic              out_vld_q;
  logic [LevelW-1:0] out_red_q, out_green_q, out_blue_q;
  logic              out_dead_q;

  logic              out_free, adv, in_acc;
  logic              pend_solid;
  logic [DecayW-1:0] decay;
  logic [LevelW-1:0] red_lvl, green_lvl, blue_lvl;
  logic              dead;

  llb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: result register frees when empty or taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_red_q   <= red_in_i;
      in_green_q <= green_in_i;
      in_blue_q  <= blue_in_i;
      in_solid_q <= solid_i;
      in_first_q <= first_in_line_i;
      in_edge_q  <= edge_solid_i;
    end
  end

  // Material of the previous cell picks the decay
  assign pend_solid = in_first_q ? in_edge_q : pend_solid_q;
  assign decay      = pend_solid ? cfg.decay_solid : cfg.decay_air;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_solid_q <= 1'b0;
    end else if (adv) begin
      pend_solid_q <= in_solid_q;
    end
  end

  llb_lane u_lane_red (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .first_i   (in_first_q),
    .level_i   (in_red_q),
    .decay_i   (decay),
    .epsilon_i (cfg.epsilon),
    .level_o   (red_lvl)
  );

  llb_lane u_lane_green (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .first_i   (in_first_q),
    .level_i   (in_green_q),
    .decay_i   (decay),
    .epsilon_i (cfg.epsilon),
    .level_o   (green_lvl)
  );

  llb_lane u_lane_blue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .first_i   (in_first_q),
    .level_i   (in_blue_q),
    .decay_i   (decay),
    .epsilon_i (cfg.epsilon),
    .level_o   (blue_lvl)
  );

  // All three channels dark
  assign dead = (red_lvl < cfg.epsilon) && (green_lvl < cfg.epsilon) &&
                (blue_lvl < cfg.epsilon);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_red_q   <= red_lvl;
      out_green_q <= green_lvl;
      out_blue_q  <= blue_lvl;
      out_dead_q  <= dead;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign red_out_o       = out_red_q;
  assign green_out_o     = out_green_q;
  assign blue_out_o      = out_blue_q;
  assign fully_decayed_o = out_dead_q;

endmodule

@@ sv/llb_checker.sv @@
// Port-level checker for the light decay blur and its bind to the top level.
module llb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [llb_pkg::LevelW-1:0]    red_out_o,
  input logic [llb_pkg::LevelW-1:0]    green_out_o,
  input logic [llb_pkg::LevelW-1:0]    blue_out_o,
  input logic                          fully_decayed_o
);
  import llb_pkg::*;

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o) &&
      $stable(green_out_o) && $stable(blue_out_o) && $stable(fully_decayed_o))
    else $error("stalled result changed");

  // Input side backs up only when both registers are full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A new result comes from a request that was accepted into the input register before it
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

  // Free output side never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register is empty");

endmodule

bind line_light_decay_blur llb_checker u_llb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .red_out_o       (red_out_o),
  .green_out_o     (green_out_o),
  .blue_out_o      (blue_out_o),
  .fully_decayed_o (fully_decayed_o)
);

@@ bench/tb_line_light_decay_blur.sv @@
// Self-checking testbench for the line light decay blur: directed and random pixel lines.
`timescale 1ns / 1ps

module tb_line_light_decay_blur;
  import llb_pkg::*;

  // Index that no register answers to
  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic              solid;
    logic              first_in_line;
    logic              edge_solid;
  } pixel_t;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic              fully_decayed;
  } blur_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [LevelW-1:0]   red_in_i;
  logic [LevelW-1:0]   green_in_i;
  logic [LevelW-1:0]   blue_in_i;
  logic                solid_i;
  logic                first_in_line_i;
  logic                edge_solid_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LevelW-1:0]   red_out_o;
  logic [LevelW-1:0]   green_out_o;
  logic [LevelW-1:0]   blue_out_o;
  logic                fully_decayed_o;

  // Pixel on the input port
  pixel_t pix_cur = '0;

  pixel_t pixel_q[$];
  blur_t  blur_due_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;

  // Mirror of the config registers
  logic [LevelW-1:0] eps_cfg = EpsilonRst;
  logic [DecayW-1:0] air_cfg = DecayAirRst;
  logic [DecayW-1:0] solid_cfg = DecaySolidRst;

  // Mirror of the carried light and the material of the previous cell
  logic [LevelW-1:0] carry_lvl [3] = '{8'd0, 8'd0, 8'd0};
  logic              pend_solid = 1'b0;

  assign red_in_i        = pix_cur.red;
  assign green_in_i      = pix_cur.green;
  assign blue_in_i       = pix_cur.blue;
  assign solid_i         = pix_cur.solid;
  assign first_in_line_i = pix_cur.first_in_line;
  assign edge_solid_i    = pix_cur.edge_solid;

  line_light_decay_blur dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .solid_i        (solid_i),
    .first_in_line_i(first_in_line_i),
    .edge_solid_i   (edge_solid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .fully_decayed_o(fully_decayed_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Blur one pixel and advance the carried light
  function automatic blur_t blur_pixel(pixel_t p);
    logic [LevelW-1:0] lvl_in [3];
    logic [LevelW-1:0] peak [3];
    logic [LevelW-1:0] held;
    logic [DecayW-1:0] k;
    logic [ProdW-1:0]  prod;
    blur_t             res;
    lvl_in[0] = p.red;
    lvl_in[1] = p.green;
    lvl_in[2] = p.blue;
    // line start reloads carry and edge material
    if (p.first_in_line) begin
      for (int c = 0; c < 3; c++) carry_lvl[c] = lvl_in[c];
      pend_solid = p.edge_solid;
    end
    k = pend_solid ? solid_cfg : air_cfg;
    for (int c = 0; c < 3; c++) begin
      held = (carry_lvl[c] < eps_cfg) ? '0 : carry_lvl[c];
      peak[c] = (held < lvl_in[c]) ? lvl_in[c] : held;
      prod = peak[c] * k;
      // Q1.8 floor, saturate when decay is above one
      carry_lvl[c] = (prod[ProdW-1:8] > 255) ? 8'hFF : prod[15:8];
    end
    pend_solid = p.solid;
    res.red = peak[0];
    res.green = peak[1];
    res.blue = peak[2];
    res.fully_decayed = (peak[0] < eps_cfg) && (peak[1] < eps_cfg) && (peak[2] < eps_cfg);
    return res;
  endfunction

  function automatic pixel_t mk_pixel(int r, int g, int b, bit sol, bit first, bit edge_s);
    pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    p.solid = sol;
    p.first_in_line = first;
    p.edge_solid = edge_s;
    return p;
  endfunction

  // Append one pixel to the pending queue
  task automatic enq_pixel(input pixel_t p);
    pixel_q = {pixel_q, p};
  endtask

  // Mostly dark or near-epsilon levels so the decay tail stays visible
  function automatic logic [LevelW-1:0] rand_level();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 255);
      3, 4:    v = 0;
      8:       v = 255;
      9:       v = $urandom_range(200, 255);
      default: v = int'(eps_cfg) + $urandom_range(0, 6) - 3;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Random lines: mostly well-formed, some stray line starts and headless runs
  task automatic queue_lines(input int n);
    pixel_t p;
    int     run;
    while (n > 0) begin
      run = $urandom_range(1, 24);
      for (int i = 0; i < run && n > 0; i++) begin
        p.red = rand_level();
        p.green = rand_level();
        p.blue = rand_level();
        p.solid = 1'($urandom_range(0, 1));
        p.first_in_line = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        p.edge_solid = 1'($urandom_range(0, 1));
        enq_pixel(p);
        n--;
      end
    end
  endtask

  // Bright line start followed by dark pixels: shows decay and saturation
  task automatic queue_flare();
    enq_pixel(mk_pixel(255, 255, 255, 0, 1, 0));
    enq_pixel(mk_pixel(0, 0, 0, 1, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 1));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegEpsilon:    eps_cfg = val[LevelW-1:0];
      RegDecayAir:   air_cfg = val;
      RegDecaySolid: solid_cfg = val;
      default: ;
    endcase
  endtask

  // Wait until every request is sent and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || blur_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_flare();
    queue_lines(n / 2);
    // sender holds off until the block has drained
    wait_idle();
    queue_lines(n - n / 2);
    wait_idle();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: present requests from the pending queue, hold while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) blur_due_q = {blur_due_q, blur_pixel(pix_cur)};
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pix_cur <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    blur_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (blur_due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                   red_out_o, green_out_o, blue_out_o, fully_decayed_o);
          err_cnt++;
        end else begin
          want = blur_due_q.pop_front();
          check_field("red_out", want.red, red_out_o);
          check_field("green_out", want.green, green_out_o);
          check_field("blue_out", want.blue, blue_out_o);
          check_field("fully_decayed", want.fully_decayed, fully_decayed_o);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: carry empty, air pending, epsilon 2
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(1, 1, 1, 0, 0, 0));
    enq_pixel(mk_pixel(2, 2, 2, 0, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 1, 0, 0));
    enq_pixel(mk_pixel(255, 255, 255, 1, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    // line starts with solid and air edges, back to back
    enq_pixel(mk_pixel(255, 0, 128, 0, 1, 1));
    enq_pixel(mk_pixel(0, 255, 0, 1, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(10, 20, 30, 0, 1, 0));
    enq_pixel(mk_pixel(40, 5, 0, 1, 1, 1));
    // edge mark without line start is ignored
    enq_pixel(mk_pixel(0, 0, 0, 1, 0, 1));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(128, 64, 32, 0, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    enq_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    run_phase(0, 0, 100);

    // epsilon zero, unit air decay, solid kills the light
    write_reg(RegEpsilon, 9'd0);
    write_reg(RegDecayAir, 9'd256);
    write_reg(RegDecaySolid, 9'd0);
    write_reg(RegNone, 9'($urandom));
    run_phase(70, 0, 105);

    // top epsilon (bit 8 dropped), decay above one saturates
    write_reg(RegEpsilon, 9'h1FF);
    write_reg(RegDecayAir, 9'd511);
    write_reg(RegDecaySolid, 9'd300);
    run_phase(0, 70, 105);

    write_reg(RegEpsilon, 9'd1);
    write_reg(RegDecayAir, 9'd0);
    write_reg(RegDecaySolid, 9'd256);
    run_phase(21, 21, 105);

    write_reg(RegEpsilon, 9'($urandom_range(0, 40)));
    write_reg(RegDecayAir, 9'($urandom_range(0, 511)));
    write_reg(RegDecaySolid, 9'($urandom_range(0, 511)));
    write_reg(RegNone, 9'($urandom));
    run_phase(70, 70, 105);

    write_reg(RegEpsilon, 9'($urandom_range(0, 511)));
    write_reg(RegDecayAir, 9'($urandom_range(128, 300)));
    write_reg(RegDecaySolid, 9'($urandom_range(0, 256)));
    run_phase(0, 0, 105);

    if (err_cnt == 0 && blur_due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
